// ===== hdl/gpr5_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gpr5_pkg;

    localparam int NUM_STOPS   = 5;
    localparam int NUM_CHAN    = 3;
    localparam int CHAN_W      = 8;
    localparam int COLOR_W     = NUM_CHAN * CHAN_W;
    localparam int POS_W       = 18;
    localparam int S_TDATA_W   = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int STOP_IDX_W  = $clog2(NUM_STOPS);
    localparam int QUEUE_DEPTH = 4;

    typedef logic [1:0]         seg_t;
    typedef logic [COLOR_W-1:0] color_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STOP_COLOR_0 = 3'd0,
        REG_STOP_COLOR_1 = 3'd1,
        REG_STOP_COLOR_2 = 3'd2,
        REG_STOP_COLOR_3 = 3'd3,
        REG_STOP_COLOR_4 = 3'd4
    } cfg_reg_t;

    localparam seg_t SEG_FIRST = 2'd0;
    localparam seg_t SEG_LAST  = 2'd3;

    localparam color_t STOP_COLOR_RESET [NUM_STOPS] = '{
        24'h08143C, 24'h1E3A8A, 24'h93C5FD, 24'hFBBF24, 24'hFFF1D6
    };

endpackage

`default_nettype wire

// ===== hdl/gradient_palette_ramp5_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Five-stop piecewise-linear color map from a signed Q1.16 position to 24-bit RGB.
// The input stream carries one position per beat in s_tdata and the output stream
// returns one color per beat in m_tdata, in the same order.
// A front stage classifies each position into its segment and offset and pushes it
// into a four-entry queue; a back pipeline scales the offset by the segment's
// reciprocal, saturates the ratio and blends the two stop colors per channel.
// One beat is accepted every cycle while the queue is not full; the rate is set by
// the three-stage back pipeline, which advances once per cycle while its output
// register is free or being taken. When the receiver holds m_tready low with a beat
// in the output register, the back pipeline freezes, the queue fills, and s_tready
// drops once all four queue entries are in use. The user writes the stop colors
// through the cfg port only while the block is idle; the block does not enforce
// this. Reset empties the queue and pipeline and restores the default stop colors.

module gradient_palette_ramp5_top
    import gpr5_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // position[17:0], zero padding[23:18]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [COLOR_W-1:0]   m_tdata,   // rgb_color[23:0]
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]   cfg_data
);

    localparam int ITEM_W = FRAC_BITS + 3;

    color_t               color_reg [NUM_STOPS];
    seg_t                 front_seg;
    logic [FRAC_BITS-1:0] front_offset;
    logic                 front_saturate;
    logic                 q_push;
    logic                 q_full;
    logic                 q_pop;
    logic                 q_valid;
    logic [ITEM_W-1:0]    q_rd_data;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STOPS; i++)
            begin
                color_reg[i] <= STOP_COLOR_RESET[i];
            end
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_STOP_COLOR_0: color_reg[0] <= cfg_data;
                REG_STOP_COLOR_1: color_reg[1] <= cfg_data;
                REG_STOP_COLOR_2: color_reg[2] <= cfg_data;
                REG_STOP_COLOR_3: color_reg[3] <= cfg_data;
                REG_STOP_COLOR_4: color_reg[4] <= cfg_data;
                default:          ;
            endcase
        end
    end

    gpr5_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .position  (s_tdata[POS_W-1:0]),
        .seg       (front_seg),
        .offset    (front_offset),
        .saturate  (front_saturate)
    );

    gpr5_queue #(
        .WIDTH     (ITEM_W),
        .DEPTH     (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wr_data   ({front_saturate, front_seg, front_offset}),
        .full      (q_full),
        .pop       (q_pop),
        .rd_valid  (q_valid),
        .rd_data   (q_rd_data)
    );

    gpr5_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (q_valid),
        .in_ready    (q_pop),
        .in_seg      (q_rd_data[FRAC_BITS+1:FRAC_BITS]),
        .in_offset   (q_rd_data[FRAC_BITS-1:0]),
        .in_saturate (q_rd_data[FRAC_BITS+2]),
        .stop_color  (color_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

`default_nettype wire

// ===== hdl/gpr5_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gpr5_front
    import gpr5_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic signed [POS_W-1:0]     position,
    output seg_t                        seg,
    output logic        [FRAC_BITS-1:0] offset,
    output logic                        saturate
);

    localparam int UW = (FRAC_BITS + 1 > POS_W - 1) ? FRAC_BITS + 1 : POS_W - 1;
    localparam longint ONE = longint'(1) << FRAC_BITS;
    localparam longint P1  = (30 * ONE + 50) / 100;
    localparam longint P2  = (55 * ONE + 50) / 100;
    localparam longint P3  = (78 * ONE + 50) / 100;

    logic [UW-1:0] ut;
    logic [UW-1:0] lo;

    always_comb
    begin
        ut       = UW'(position[POS_W-2:0]);
        lo       = '0;
        seg      = SEG_FIRST;
        offset   = '0;
        saturate = 1'b0;
        if (position[POS_W-1] || (position == '0))
        begin
            seg = SEG_FIRST;
        end
        else if (ut >= UW'(ONE))
        begin
            seg      = SEG_LAST;
            saturate = 1'b1;
        end
        else
        begin
            if (ut > UW'(P3))
            begin
                seg = 2'd3;
                lo  = UW'(P3);
            end
            else if (ut > UW'(P2))
            begin
                seg = 2'd2;
                lo  = UW'(P2);
            end
            else if (ut > UW'(P1))
            begin
                seg = 2'd1;
                lo  = UW'(P1);
            end
            else
            begin
                seg = 2'd0;
                lo  = '0;
            end
            offset = FRAC_BITS'(ut - lo);
        end
    end

endmodule

`default_nettype wire

// ===== hdl/gpr5_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gpr5_queue
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic             rd_valid,
    output logic [WIDTH-1:0] rd_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_pop   = pop && rd_valid;

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/gpr5_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gpr5_back
    import gpr5_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  seg_t                 in_seg,
    input  logic [FRAC_BITS-1:0] in_offset,
    input  logic                 in_saturate,
    input  color_t               stop_color [NUM_STOPS],
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [COLOR_W-1:0]   m_tdata
);

    localparam longint ONE = longint'(1) << FRAC_BITS;
    localparam longint P1  = (30 * ONE + 50) / 100;
    localparam longint P2  = (55 * ONE + 50) / 100;
    localparam longint P3  = (78 * ONE + 50) / 100;
    localparam longint W0  = P1;
    localparam longint W1  = P2 - P1;
    localparam longint W2  = P3 - P2;
    localparam longint W3  = ONE - P3;
    localparam longint K0  = ((ONE << FRAC_BITS) + W0 / 2) / W0;
    localparam longint K1  = ((ONE << FRAC_BITS) + W1 / 2) / W1;
    localparam longint K2  = ((ONE << FRAC_BITS) + W2 / 2) / W2;
    localparam longint K3  = ((ONE << FRAC_BITS) + W3 / 2) / W3;
    localparam int KW  = FRAC_BITS + 3;
    localparam int PRW = FRAC_BITS + KW;
    localparam int RW  = FRAC_BITS + 1;
    localparam int SW  = FRAC_BITS + CHAN_W + 1;

    logic                  pipe_en;
    logic [KW-1:0]         kval;
    logic [PRW-1:0]        prod_next;
    logic [KW-1:0]         ratio_hi;
    logic [RW-1:0]         ratio_next;
    logic [STOP_IDX_W-1:0] idx_a;
    logic [STOP_IDX_W-1:0] idx_b;
    color_t                color_a;
    color_t                color_b;
    logic [SW-1:0]         mix_sum [NUM_CHAN];
    logic [COLOR_W-1:0]    mix_next;

    logic                  v1_reg;
    seg_t                  seg1_reg;
    logic                  sat1_reg;
    logic [PRW-1:0]        prod1_reg;
    logic                  v2_reg;
    seg_t                  seg2_reg;
    logic [RW-1:0]         ratio2_reg;
    logic                  m_tvalid_reg;
    logic [COLOR_W-1:0]    m_tdata_reg;

    assign pipe_en  = !m_tvalid_reg || m_tready;
    assign in_ready = pipe_en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        case (in_seg)
            2'd0:    kval = KW'(K0);
            2'd1:    kval = KW'(K1);
            2'd2:    kval = KW'(K2);
            default: kval = KW'(K3);
        endcase
        prod_next = PRW'(in_offset) * PRW'(kval);
    end

    always_comb
    begin
        ratio_hi = prod1_reg[PRW-1:FRAC_BITS];
        if (sat1_reg || (ratio_hi > KW'(ONE)))
        begin
            ratio_next = RW'(ONE);
        end
        else
        begin
            ratio_next = RW'(ratio_hi);
        end
    end

    always_comb
    begin
        idx_a   = STOP_IDX_W'(seg2_reg);
        idx_b   = STOP_IDX_W'(seg2_reg) + STOP_IDX_W'(1);
        color_a = stop_color[idx_a];
        color_b = stop_color[idx_b];
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            mix_sum[c] = SW'(color_a[c*CHAN_W +: CHAN_W]) * SW'(RW'(ONE) - ratio2_reg)
                       + SW'(color_b[c*CHAN_W +: CHAN_W]) * SW'(ratio2_reg);
            mix_next[c*CHAN_W +: CHAN_W] = mix_sum[c][FRAC_BITS+CHAN_W-1:FRAC_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            v1_reg       <= in_valid;
            v2_reg       <= v1_reg;
            m_tvalid_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            seg1_reg    <= in_seg;
            sat1_reg    <= in_saturate;
            prod1_reg   <= prod_next;
            seg2_reg    <= seg1_reg;
            ratio2_reg  <= ratio_next;
            m_tdata_reg <= mix_next;
        end
    end

endmodule

`default_nettype wire
